>>> rtl/core/swtd_pkg.sv
// Shared types and constants for the sliding window tone detector.
// Used by every module under rtl/core except swtd_line; no dependencies.
package swtd_pkg;

    localparam int COEF_W     = 16;   // oscillator coefficient, Q1.15
    localparam int LEVEL_W    = 16;   // tone level result
    localparam int PHASE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int WIN_CFG_W  = 11;   // window_length register field
    localparam int FRAC_BITS  = 15;

    localparam int MIN_WINDOW   = 4;
    localparam int WINDOW_RESET = 176;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h8000;

    // 2*pi in Q30, and the Taylor series divisors (2n)(2n+1) for sine
    localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
    localparam int              TAYLOR_TERMS = 9;
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP    = 2'd0,
        REG_WINDOW_LENGTH = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_COS,
        SEQ_SIN,
        SEQ_MUL_SIN,
        SEQ_ACC,
        SEQ_SQ_RE,
        SEQ_SQ_IM,
        SEQ_SQ_SUM,
        SEQ_START,
        SEQ_WAIT,
        SEQ_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        SQD_IDLE,
        SQD_ROOT,
        SQD_SAT,
        SQD_DIV,
        SQD_DONE
    } sqd_state_t;

    typedef struct packed {
        logic clear;    // zero the phase
        logic advance;  // latch table index, step the phase
        logic sel_cos;  // read the cosine (quarter turn ahead) this cycle
    } osc_ctrl_t;

endpackage

>>> rtl/core/swtd_osc.sv
// Local oscillator: phase accumulator and quarter-wave sine ROM, registered read.
// Depends on swtd_pkg.
module swtd_osc #(
    parameter int TABLE_BITS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [swtd_pkg::PHASE_W-1:0]          phase_step,
    input  swtd_pkg::osc_ctrl_t                   ctrl,
    output logic signed [swtd_pkg::COEF_W-1:0]    coef
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam int QIDX_W     = TABLE_BITS - 1;
    localparam int QVAL_W     = swtd_pkg::COEF_W + 1;
    localparam logic signed [QVAL_W:0] COEF_POS_MAX = (QVAL_W + 1)'(2 ** (swtd_pkg::COEF_W - 1) - 1);
    localparam logic signed [swtd_pkg::COEF_W-1:0] COEF_SAT =
        swtd_pkg::COEF_W'(2 ** (swtd_pkg::COEF_W - 1) - 1);

    // Quarter-wave sine in Q1.15 (0..32768), Q30 Taylor series
    function automatic logic [QVAL_W*(QUARTER+1)-1:0] build_qtab();
        logic [QVAL_W*(QUARTER+1)-1:0] tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        tab = '0;
        for (int r = 0; r <= QUARTER; r++) begin
            x    = (swtd_pkg::TWO_PI_Q30 * longint'(r) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= swtd_pkg::TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / swtd_pkg::TAYLOR_DIV[n];
                if ((n & 1) != 0) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            tab[r*QVAL_W +: QVAL_W] = QVAL_W'((longint'(acc) + 64'd16384) >> 15);
        end
        return tab;
    endfunction

    localparam logic [QVAL_W*(QUARTER+1)-1:0] QTAB = build_qtab();

    logic [swtd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [TABLE_BITS-1:0]        k_reg, k_next;
    logic [TABLE_BITS-1:0]        addr;
    logic [1:0]                   quad;
    logic [QIDX_W-1:0]            qidx;
    logic [QVAL_W-1:0]            qval_reg;
    logic                         neg_reg;
    logic signed [QVAL_W:0]       sval;

    always_comb begin
        phase_next = phase_reg;
        k_next     = k_reg;
        if (ctrl.clear) begin
            phase_next = '0;
        end else if (ctrl.advance) begin
            k_next     = phase_reg[swtd_pkg::PHASE_W-1 -: TABLE_BITS];
            phase_next = phase_reg + phase_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            k_reg     <= '0;
        end else begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

    // fold the full-turn index onto the quarter table
    assign addr = ctrl.sel_cos ? k_reg + TABLE_BITS'(QUARTER) : k_reg;
    assign quad = addr[TABLE_BITS-1 -: 2];
    assign qidx = quad[0] ? QIDX_W'(QUARTER) - {1'b0, addr[TABLE_BITS-3:0]}
                          : {1'b0, addr[TABLE_BITS-3:0]};

    always_ff @(posedge aclk) begin
        qval_reg <= QTAB[int'(qidx)*QVAL_W +: QVAL_W];
        neg_reg  <= quad[1];
    end

    // +1.0 saturates to 32767; -1.0 stays
    assign sval = neg_reg ? -$signed({1'b0, qval_reg}) : $signed({1'b0, qval_reg});
    assign coef = (sval > COEF_POS_MAX) ? COEF_SAT : sval[swtd_pkg::COEF_W-1:0];

endmodule

>>> rtl/core/swtd_line.sv
// Single-port delay line RAM, read-before-write, registered read data.
// Depends on nothing.
module swtd_line #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 34
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/swtd_sqdiv.sv
// Iterative square root then divide by the window, one shared subtractor.
// Depends on swtd_pkg.
module swtd_sqdiv #(
    parameter int ROOT_W = 26,
    parameter int WIN_W  = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [2*ROOT_W-1:0]                radicand,
    input  logic [WIN_W-1:0]                   window,
    output logic                               done,
    output logic [swtd_pkg::LEVEL_W-1:0]       level
);

    localparam int SQ_W     = 2 * ROOT_W;
    localparam int QUOT_W   = swtd_pkg::FRAC_BITS;
    localparam int SUB_W    = ROOT_W + 3;
    localparam int ITER_MAX = (ROOT_W > QUOT_W) ? ROOT_W : QUOT_W;
    localparam int CNT_W    = $clog2(ITER_MAX);

    swtd_pkg::sqd_state_t state_reg, state_next;
    logic [SQ_W-1:0]      rad_reg, rad_next;
    logic [SUB_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [swtd_pkg::LEVEL_W-1:0] level_reg, level_next;

    // shared subtract / compare
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ok;

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok   = !sub_diff[SUB_W];

    always_comb begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        level_next = level_reg;
        sub_a      = '0;
        sub_b      = '0;
        unique case (state_reg)
            swtd_pkg::SQD_IDLE: begin
                if (start) begin
                    rad_next   = radicand;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_W - 1);
                    state_next = swtd_pkg::SQD_ROOT;
                end
            end
            swtd_pkg::SQD_ROOT: begin
                // one root bit per cycle: trial = 4*root + 1
                sub_a    = {rem_reg[SUB_W-3:0], rad_reg[SQ_W-1 -: 2]};
                sub_b    = SUB_W'({root_reg, 2'b01});
                rem_next = sub_ok ? sub_diff[SUB_W-1:0] : sub_a;
                root_next = {root_reg[ROOT_W-2:0], sub_ok};
                rad_next = {rad_reg[SQ_W-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    state_next = swtd_pkg::SQD_SAT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            swtd_pkg::SQD_SAT: begin
                // quotient >= 2^15 exactly when root >> 15 >= window
                sub_a = SUB_W'(root_reg >> QUOT_W);
                sub_b = SUB_W'(window);
                if (sub_ok) begin
                    level_next = swtd_pkg::LEVEL_MAX;
                    state_next = swtd_pkg::SQD_DONE;
                end else begin
                    rem_next   = sub_a;
                    quot_next  = QUOT_W'(root_reg);
                    cnt_next   = CNT_W'(QUOT_W - 1);
                    state_next = swtd_pkg::SQD_DIV;
                end
            end
            swtd_pkg::SQD_DIV: begin
                // restoring divide, dividend bits shift out as quotient bits shift in
                sub_a     = {rem_reg[SUB_W-2:0], quot_reg[QUOT_W-1]};
                sub_b     = SUB_W'(window);
                rem_next  = sub_ok ? sub_diff[SUB_W-1:0] : sub_a;
                quot_next = {quot_reg[QUOT_W-2:0], sub_ok};
                if (cnt_reg == '0) begin
                    level_next = swtd_pkg::LEVEL_W'(quot_next);
                    state_next = swtd_pkg::SQD_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            swtd_pkg::SQD_DONE: begin
                state_next = swtd_pkg::SQD_IDLE;
            end
            default: begin
                state_next = swtd_pkg::SQD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swtd_pkg::SQD_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        quot_reg  <= quot_next;
        level_reg <= level_next;
    end

    assign done  = (state_reg == swtd_pkg::SQD_DONE);
    assign level = level_reg;

endmodule

>>> rtl/core/sliding_window_tone_detector.sv
// Sliding window quadrature tone detector, top level: sequencer, shared multiplier, sums.
// Takes one sample at a time: s_tready is low from acceptance until the level is passed
//   to the output register, which waits on m_tready. The square-root loop (SAMPLE_BITS +
//   clog2(MAX_WINDOW) steps) and 15-step divide share one subtractor; saturation skips it.
// Reset (aresetn low, synchronous): phase step 0, window 176, phase, sums, pointer cleared;
//   delay line entries read as zero until rewritten; no RAM clearing pass.
// Depends on swtd_pkg, swtd_osc, swtd_line, swtd_sqdiv.
module sliding_window_tone_detector #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int TABLE_BITS  = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // [SAMPLE_BITS-1:0] sample
    // level stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [swtd_pkg::LEVEL_W-1:0]          m_tdata,   // [15:0] tone_level
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swtd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swtd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int MIX_W   = SAMPLE_BITS + 1;             // rounded mixer output
    localparam int SUM_W   = MIX_W + $clog2(MAX_WINDOW);  // exact window sum
    localparam int ROOT_W  = SUM_W - 1;                   // |sum| bound
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int MUL_W   = SUM_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIN_RST = (swtd_pkg::WINDOW_RESET < MAX_WINDOW) ?
                             swtd_pkg::WINDOW_RESET : MAX_WINDOW;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (swtd_pkg::FRAC_BITS - 1);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    swtd_pkg::seq_state_t state_reg, state_next;

    logic [swtd_pkg::PHASE_W-1:0] step_reg, step_next;
    logic [WIN_W-1:0]             win_reg, win_next;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic                         fill_reg, fill_next;   // pointer has wrapped since clear
    logic signed [SUM_W-1:0]      sum_re_reg, sum_re_next;
    logic signed [SUM_W-1:0]      sum_im_reg, sum_im_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [MIX_W-1:0]       re_reg, re_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [SQ_W-1:0]               sq_reg, sq_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [swtd_pkg::LEVEL_W-1:0]  m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------------
    // Datapath wires
    // ---------------------------------------------------------------------
    swtd_pkg::osc_ctrl_t              osc_ctrl;
    logic signed [swtd_pkg::COEF_W-1:0] coef;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] p_rnd, n_rnd, p_shift, n_shift;
    logic signed [MIX_W-1:0]  mix_re, mix_im;

    logic                     line_we;
    logic [2*MIX_W-1:0]       line_rdata;
    logic signed [MIX_W-1:0]  old_re, old_im;

    logic                     sqd_start;
    logic                     sqd_done;
    logic [swtd_pkg::LEVEL_W-1:0] sqd_level;

    logic                     cfg_fire;
    logic                     win_clear;
    logic [WIN_W-1:0]         win_last;
    logic [swtd_pkg::WIN_CFG_W-1:0] win_cfg;

    // ---------------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------------
    swtd_osc #(
        .TABLE_BITS (TABLE_BITS)
    ) u_osc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .phase_step (step_reg),
        .ctrl       (osc_ctrl),
        .coef       (coef)
    );

    swtd_line #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PTR_W),
        .DATA_W (2 * MIX_W)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .addr  (wp_reg),
        .wdata ({re_reg, mix_im}),
        .rdata (line_rdata)
    );

    swtd_sqdiv #(
        .ROOT_W (ROOT_W),
        .WIN_W  (WIN_W)
    ) u_sqdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqd_start),
        .radicand (sq_reg),
        .window   (win_reg),
        .done     (sqd_done),
        .level    (sqd_level)
    );

    // shared multiplier, registered product
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Q15 rounding: floor((p + 2^14) / 2^15); imaginary part uses -x*sin
    assign p_rnd   = prod_reg + ROUND_HALF;
    assign n_rnd   = ROUND_HALF - prod_reg;
    assign p_shift = p_rnd >>> swtd_pkg::FRAC_BITS;
    assign n_shift = n_rnd >>> swtd_pkg::FRAC_BITS;
    assign mix_re  = p_shift[MIX_W-1:0];
    assign mix_im  = n_shift[MIX_W-1:0];

    // entries not yet written since the last clear read as zero
    assign old_re = fill_reg ? line_rdata[2*MIX_W-1 -: MIX_W] : '0;
    assign old_im = fill_reg ? line_rdata[MIX_W-1:0] : '0;

    assign win_last = win_reg - WIN_W'(1);
    assign cfg_fire = cfg_valid && cfg_ready;
    assign win_cfg  = cfg_data[swtd_pkg::WIN_CFG_W-1:0];

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_comb begin
        step_next = step_reg;
        win_next  = win_reg;
        win_clear = 1'b0;
        if (cfg_fire) begin
            unique case (swtd_pkg::cfg_reg_t'(cfg_index))
                swtd_pkg::REG_PHASE_STEP: begin
                    step_next = cfg_data;
                end
                swtd_pkg::REG_WINDOW_LENGTH: begin
                    win_clear = 1'b1;
                    if (int'(win_cfg) < swtd_pkg::MIN_WINDOW) begin
                        win_next = WIN_W'(swtd_pkg::MIN_WINDOW);
                    end else if (int'(win_cfg) > MAX_WINDOW) begin
                        win_next = WIN_W'(MAX_WINDOW);
                    end else begin
                        win_next = WIN_W'(win_cfg);
                    end
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        sum_re_next   = sum_re_reg;
        sum_im_next   = sum_im_reg;
        x_next        = x_reg;
        re_next       = re_reg;
        sq_next       = sq_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        osc_ctrl      = '0;
        mul_a         = '0;
        mul_b         = '0;
        line_we       = 1'b0;
        sqd_start     = 1'b0;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            swtd_pkg::SEQ_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next           = s_tdata[SAMPLE_BITS-1:0];
                    osc_ctrl.advance = 1'b1;
                    state_next       = swtd_pkg::SEQ_COS;
                end
            end
            swtd_pkg::SEQ_COS: begin
                osc_ctrl.sel_cos = 1'b1;
                state_next       = swtd_pkg::SEQ_SIN;
            end
            swtd_pkg::SEQ_SIN: begin
                // coef holds cosine; sine read in flight
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(coef);
                state_next = swtd_pkg::SEQ_MUL_SIN;
            end
            swtd_pkg::SEQ_MUL_SIN: begin
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(coef);
                re_next    = mix_re;
                state_next = swtd_pkg::SEQ_ACC;
            end
            swtd_pkg::SEQ_ACC: begin
                // drop the oldest entry, add the new one, overwrite in place
                sum_re_next = sum_re_reg - SUM_W'(old_re) + SUM_W'(re_reg);
                sum_im_next = sum_im_reg - SUM_W'(old_im) + SUM_W'(mix_im);
                line_we     = 1'b1;
                if (WIN_W'(wp_reg) == win_last) begin
                    wp_next   = '0;
                    fill_next = 1'b1;
                end else begin
                    wp_next = wp_reg + PTR_W'(1);
                end
                state_next = swtd_pkg::SEQ_SQ_RE;
            end
            swtd_pkg::SEQ_SQ_RE: begin
                mul_a      = sum_re_reg;
                mul_b      = sum_re_reg;
                state_next = swtd_pkg::SEQ_SQ_IM;
            end
            swtd_pkg::SEQ_SQ_IM: begin
                mul_a      = sum_im_reg;
                mul_b      = sum_im_reg;
                sq_next    = prod_reg[SQ_W-1:0];
                state_next = swtd_pkg::SEQ_SQ_SUM;
            end
            swtd_pkg::SEQ_SQ_SUM: begin
                sq_next    = sq_reg + prod_reg[SQ_W-1:0];
                state_next = swtd_pkg::SEQ_START;
            end
            swtd_pkg::SEQ_START: begin
                sqd_start  = 1'b1;
                state_next = swtd_pkg::SEQ_WAIT;
            end
            swtd_pkg::SEQ_WAIT: begin
                if (sqd_done) begin
                    state_next = swtd_pkg::SEQ_OUT;
                end
            end
            swtd_pkg::SEQ_OUT: begin
                // result register free or being emptied this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sqd_level;
                    state_next    = swtd_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = swtd_pkg::SEQ_IDLE;
            end
        endcase

        // window write clears the integrator and the phase
        if (win_clear) begin
            wp_next        = '0;
            fill_next      = 1'b0;
            sum_re_next    = '0;
            sum_im_next    = '0;
            osc_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= swtd_pkg::SEQ_IDLE;
            step_reg     <= '0;
            win_reg      <= WIN_W'(WIN_RST);
            wp_reg       <= '0;
            fill_reg     <= 1'b0;
            sum_re_reg   <= '0;
            sum_im_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            win_reg      <= win_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            sum_re_reg   <= sum_re_next;
            sum_im_reg   <= sum_im_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        re_reg      <= re_next;
        sq_reg      <= sq_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= swtd_pkg::LEVEL_MAX)
        else $error("tone level above saturation limit");

    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        WIN_W'(wp_reg) < win_reg)
        else $error("write pointer outside window");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while previous one in work");

    a_window_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == swtd_pkg::REG_WINDOW_LENGTH
        |=> wp_reg == '0 && !fill_reg && sum_re_reg == '0 && sum_im_reg == '0)
        else $error("window write did not clear the integrator");

endmodule
